// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the stream find-and-replace RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SFR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sfr assertion failed");

// Checks an implication on every rising clock edge outside reset.
`define SFR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfr assertion failed");

`endif

// ===== rtl/sfr_pkg.sv =====
// Types, constants and helper functions of the stream find-and-replace block.
package sfr_pkg;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int BYTES_MAX       = 8;
  localparam int CNT_W           = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int LEN_W           = 4;
  localparam int MATCH_W         = 3;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES = 2'd0,
    CFG_PATTERN_LEN   = 2'd1,
    CFG_REPLACE_BYTES = 2'd2,
    CFG_REPLACE_LEN   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } sfr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    count_t     text_in_count;
    count_t     text_out_count;
    count_t     subst_count;
  } sfr_out_t;

  // One queued work item: up to eight bytes to send, plus the end-of-text counts.
  typedef struct packed {
    logic [8*BYTES_MAX-1:0] data;
    len_t                   cnt;
    logic                   last;
    count_t                 in_cnt;
    count_t                 out_cnt;
    count_t                 subst_cnt;
  } sfr_entry_t;

  function automatic count_t sat_add(count_t v, len_t n);
    logic [CNT_W:0] sum;
    sum = {1'b0, v} + {{(CNT_W + 1 - LEN_W){1'b0}}, n};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/sfr_front.sv =====
// Front end: configuration registers, pattern matching and per-transfer classification.
`include "assert_macros.svh"
module sfr_front #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]          cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  sfr_pkg::sfr_in_t                        in_data,
  input  logic                                    q_full,
  output logic                                    q_push,
  output sfr_pkg::sfr_entry_t                     q_push_data
);
  import sfr_pkg::*;

  localparam len_t PLEN_MAX = len_t'(MAX_PATTERN);
  localparam len_t RLEN_MAX = len_t'(BYTES_MAX);

  logic [8*MAX_PATTERN-1:0] pat_r;
  len_t                     pat_len_r;
  logic [8*BYTES_MAX-1:0]   rep_r;
  len_t                     rep_len_r;
  logic [MATCH_W-1:0]       match_r, match_nxt;
  count_t                   in_cnt_r, in_cnt_nxt;
  count_t                   out_cnt_r, out_cnt_nxt;
  count_t                   subst_cnt_r, subst_cnt_nxt;

  logic [7:0]         pat_b [BYTES_MAX];
  logic [7:0]         buf_b [BYTES_MAX];
  len_t               plen, rlen, m_ext, m_inc, cnt;
  logic               hit, full_hit, accept;
  logic [MATCH_W-1:0] border;
  logic [7:0]         c;

  assign c        = in_data.in_byte;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign m_ext    = {1'b0, match_r};
  assign m_inc    = m_ext + len_t'(1);

  always_comb begin
    if (pat_len_r == '0) begin
      plen = len_t'(1);
    end else if (pat_len_r > PLEN_MAX) begin
      plen = PLEN_MAX;
    end else begin
      plen = pat_len_r;
    end
    rlen = (rep_len_r > RLEN_MAX) ? RLEN_MAX : rep_len_r;
  end

  always_comb begin
    for (int i = 0; i < BYTES_MAX; i++) begin
      pat_b[i] = '0;
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat_b[i] = pat_r[8*i +: 8];
    end
    for (int i = 0; i < BYTES_MAX; i++) begin
      buf_b[i] = (MATCH_W'(i) < match_r) ? pat_b[i] : c;
    end
  end

  assign hit      = (m_ext < plen) && (pat_b[match_r] == c);
  assign full_hit = hit && (m_inc == plen);

  // Longest suffix of the pending bytes plus the new byte that is a proper prefix.
  always_comb begin
    logic               ok;
    logic [MATCH_W-1:0] idx;
    border = '0;
    for (int k = 1; k < BYTES_MAX; k++) begin
      ok = 1'b1;
      for (int j = 0; j < k; j++) begin
        idx = match_r + MATCH_W'(1) - MATCH_W'(k) + MATCH_W'(j);
        if (buf_b[idx] != pat_b[j]) begin
          ok = 1'b0;
        end
      end
      if (ok && (len_t'(k) <= m_ext) && (len_t'(k) <= plen - len_t'(1))) begin
        border = MATCH_W'(k);
      end
    end
  end

  always_comb begin
    if (full_hit) begin
      cnt       = rlen;
      match_nxt = '0;
    end else if (hit) begin
      cnt       = in_data.in_last ? m_inc : '0;
      match_nxt = m_inc[MATCH_W-1:0];
    end else begin
      cnt       = in_data.in_last ? m_inc : (m_inc - {1'b0, border});
      match_nxt = border;
    end
    if (in_data.in_last) begin
      match_nxt = '0;
    end
    in_cnt_nxt    = sat_add(in_cnt_r, len_t'(1));
    out_cnt_nxt   = sat_add(out_cnt_r, cnt);
    subst_cnt_nxt = full_hit ? sat_add(subst_cnt_r, len_t'(1)) : subst_cnt_r;
  end

  always_comb begin
    q_push_data.cnt       = cnt;
    q_push_data.last      = in_data.in_last;
    q_push_data.in_cnt    = in_cnt_nxt;
    q_push_data.out_cnt   = out_cnt_nxt;
    q_push_data.subst_cnt = subst_cnt_nxt;
    for (int i = 0; i < BYTES_MAX; i++) begin
      q_push_data.data[8*i +: 8] = full_hit ? rep_r[8*i +: 8] : buf_b[i];
    end
  end

  assign q_push = accept && ((cnt != '0) || in_data.in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r     <= '0;
      pat_len_r <= len_t'(1);
      rep_r     <= '0;
      rep_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PATTERN_BYTES: pat_r     <= cfg_wdata[8*MAX_PATTERN-1:0];
        CFG_PATTERN_LEN:   pat_len_r <= cfg_wdata[LEN_W-1:0];
        CFG_REPLACE_BYTES: rep_r     <= cfg_wdata[8*BYTES_MAX-1:0];
        CFG_REPLACE_LEN:   rep_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r     <= '0;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      subst_cnt_r <= '0;
    end else if (accept) begin
      match_r     <= match_nxt;
      in_cnt_r    <= in_data.in_last ? '0 : in_cnt_nxt;
      out_cnt_r   <= in_data.in_last ? '0 : out_cnt_nxt;
      subst_cnt_r <= in_data.in_last ? '0 : subst_cnt_nxt;
    end
  end

  `SFR_ASSERT_IMP(a_front_cnt_range, q_push, q_push_data.cnt <= len_t'(BYTES_MAX))
  `SFR_ASSERT_IMP(a_front_idle_after_last, $past(accept && in_data.in_last),
                  match_r == '0 && in_cnt_r == '0)

endmodule

// ===== rtl/sfr_queue.sv =====
// Short work queue between the front end and the output sequencer.
`include "assert_macros.svh"
module sfr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sfr_pkg::sfr_entry_t push_data,
  output logic                full,
  output logic                pop_valid,
  input  logic                pop,
  output sfr_pkg::sfr_entry_t pop_data
);
  import sfr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(QUEUE_DEPTH);

  sfr_entry_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  fill_r, fill_nxt;
  logic               do_pop;

  assign full      = (fill_r == CNT_FULL);
  assign pop_valid = (fill_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      fill_nxt = fill_r + CNT_QW'(1);
    end else if (do_pop && !push) begin
      fill_nxt = fill_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  `SFR_ASSERT(a_queue_no_overflow, !(push && full))
  `SFR_ASSERT(a_queue_fill_bound, fill_r <= CNT_FULL)

endmodule

// ===== rtl/sfr_back.sv =====
// Back end: steps through each queued entry and drives the registered result channel.
`include "assert_macros.svh"
module sfr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sfr_pkg::sfr_entry_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output sfr_pkg::sfr_out_t   out_data
);
  import sfr_pkg::*;

  logic [MATCH_W-1:0] idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  sfr_out_t           out_r, out_nxt;
  logic               load, final_res;
  len_t               last_idx;

  assign load      = !out_valid_r || !out_stall;
  assign last_idx  = (q_data.cnt == '0) ? '0 : q_data.cnt - len_t'(1);
  assign final_res = ({1'b0, idx_r} == last_idx);
  assign q_pop     = load && q_valid && final_res;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = q_valid;
      if (q_valid) begin
        out_nxt.byte_valid = (q_data.cnt != '0);
        out_nxt.out_byte   = (q_data.cnt != '0) ? q_data.data[8*idx_r +: 8] : '0;
        out_nxt.out_last   = q_data.last && final_res;
        if (q_data.last && final_res) begin
          out_nxt.text_in_count  = q_data.in_cnt;
          out_nxt.text_out_count = q_data.out_cnt;
          out_nxt.subst_count    = q_data.subst_cnt;
        end else begin
          out_nxt.text_in_count  = '0;
          out_nxt.text_out_count = '0;
          out_nxt.subst_count    = '0;
        end
        idx_nxt = final_res ? '0 : idx_r + MATCH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SFR_ASSERT_IMP(a_back_marker_is_last, out_valid_r && !out_r.byte_valid, out_r.out_last)
  `SFR_ASSERT_IMP(a_back_counts_on_last, out_valid_r && !out_r.out_last,
                  out_r.text_in_count == '0 && out_r.subst_count == '0)

endmodule

// ===== rtl/stream_find_replace.sv =====
// Top level of the streaming find-and-replace-all block.
// A byte's results are registered in a queue slot and then in the output register.
// Throughput: one result per cycle from the output sequencer while out_stall is low; a
// byte with n results holds it for all n; others go at one per cycle while in_stall is low.
// A two-entry queue sets how far the matcher may run ahead of the output sequencer.
// Reset is synchronous: it clears the match state, counters, queue and output valid,
// and returns the configuration registers to their defaults.
`include "assert_macros.svh"
module stream_find_replace #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sfr_pkg::sfr_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sfr_pkg::sfr_out_t              out_data
);
  import sfr_pkg::*;

  logic       q_push, q_full, q_valid, q_pop;
  sfr_entry_t q_push_data, q_pop_data;

  sfr_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_data(q_push_data)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_pop_data)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
